// ===== rtl/lru_block_cache_index_macros.svh =====
// assertion helpers used by the rtl datapath
`ifndef LRU_BLOCK_CACHE_INDEX_MACROS_SVH
`define LRU_BLOCK_CACHE_INDEX_MACROS_SVH

// same-cycle implication, checked out of reset
`define LBCI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LBCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lbci_pkg.sv =====
`timescale 1ns / 1ps

package lbci_pkg;

    localparam int ENTRIES  = 8;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BLOCK_W  = 32;
    localparam int SLOT_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
    } dp_stat_t;

    // entry slot to result slot field, wrapping or zero filling as needed
    function automatic logic [SLOT_W-1:0] fit_slot(input logic [IDX_W-1:0] s);
        logic [SLOT_W+IDX_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, s};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

// ===== rtl/lbci_ctrl.sv =====
`timescale 1ns / 1ps

module lbci_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lbci_pkg::dp_stat_t stat,
    output lbci_pkg::dp_cmd_t  ctl
);

    lbci_pkg::state_t state_reg;
    lbci_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbci_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbci_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lbci_pkg::ST_SEARCH;
                end
            end
            lbci_pkg::ST_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = lbci_pkg::ST_COMMIT;
                end
            end
            lbci_pkg::ST_COMMIT:
            begin
                // wait here until the output register can take the result
                if (stat.out_free)
                begin
                    state_next = lbci_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbci_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        ctl.commit = 1'b0;
        case (state_reg)
            lbci_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            lbci_pkg::ST_SEARCH:
            begin
                ctl.step = 1'b1;
            end
            lbci_pkg::ST_COMMIT:
            begin
                ctl.commit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/lbci_datapath.sv =====
`timescale 1ns / 1ps
`include "lru_block_cache_index_macros.svh"

module lbci_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lbci_pkg::dp_cmd_t             ctl,
    output lbci_pkg::dp_stat_t            stat,
    input  logic                          in_cmd,
    input  logic [lbci_pkg::BLOCK_W-1:0]  in_block,
    input  logic                          in_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_hit,
    output logic [lbci_pkg::SLOT_W-1:0]   out_slot,
    output logic                          out_status
);

    // item registers
    logic                          cmd_reg;
    logic [lbci_pkg::BLOCK_W-1:0]  blk_reg;
    logic                          ok_reg;

    // walk registers
    logic [lbci_pkg::IDX_W-1:0]    idx_reg;
    logic                          found_reg;
    logic [lbci_pkg::IDX_W-1:0]    pos_reg;
    logic [lbci_pkg::IDX_W-1:0]    hold_slot_reg;

    // index list, position 0 is the most recent
    logic [lbci_pkg::BLOCK_W-1:0]  entry_block_reg [lbci_pkg::ENTRIES];
    logic [lbci_pkg::BLOCK_W-1:0]  entry_block_next [lbci_pkg::ENTRIES];
    logic [lbci_pkg::IDX_W-1:0]    entry_slot_reg [lbci_pkg::ENTRIES];
    logic [lbci_pkg::IDX_W-1:0]    entry_slot_next [lbci_pkg::ENTRIES];
    logic [lbci_pkg::ENTRIES-1:0]  valid_reg;
    logic [lbci_pkg::ENTRIES-1:0]  valid_next;

    // result register
    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic [lbci_pkg::SLOT_W-1:0]   out_slot_reg;
    logic                          out_status_reg;

    logic                          cur_valid;
    logic                          cur_match;
    logic                          read_hit;
    logic                          fail;
    logic [lbci_pkg::IDX_W-1:0]    head_slot;
    logic [lbci_pkg::IDX_W-1:0]    shift_pos;

    assign cur_valid = valid_reg[idx_reg];
    assign cur_match = (entry_block_reg[idx_reg] == blk_reg);

    // walk stops at the first empty entry, a match or the tail
    assign stat.search_done = !cur_valid || cur_match || (idx_reg == lbci_pkg::LAST_IDX);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign read_hit  = (cmd_reg == lbci_pkg::CMD_READ) && found_reg;
    assign fail      = !read_hit && !ok_reg;
    // a miss recycles the tail entry
    assign head_slot = found_reg ? hold_slot_reg : entry_slot_reg[lbci_pkg::LAST_IDX];
    assign shift_pos = found_reg ? pos_reg : lbci_pkg::LAST_IDX;

    always_comb
    begin
        entry_block_next = entry_block_reg;
        entry_slot_next  = entry_slot_reg;
        valid_next       = valid_reg;
        if (ctl.commit && !fail)
        begin
            for (int k = 1; k < lbci_pkg::ENTRIES; k++)
            begin
                if (lbci_pkg::IDX_W'(k) <= shift_pos)
                begin
                    entry_block_next[k] = entry_block_reg[k-1];
                    entry_slot_next[k]  = entry_slot_reg[k-1];
                    valid_next[k]       = valid_reg[k-1];
                end
            end
            entry_block_next[0] = blk_reg;
            entry_slot_next[0]  = head_slot;
            valid_next[0]       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lbci_pkg::ENTRIES; i++)
            begin
                entry_block_reg[i] <= '0;
                entry_slot_reg[i]  <= lbci_pkg::IDX_W'(i);
            end
            valid_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entry_block_reg <= entry_block_next;
            entry_slot_reg  <= entry_slot_next;
            valid_reg       <= valid_next;
            if (ctl.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (ctl.step)
            begin
                if (stat.search_done)
                begin
                    found_reg <= cur_valid && cur_match;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (ctl.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= in_cmd;
            blk_reg <= in_block;
            ok_reg  <= in_ok;
        end
        if (ctl.step && stat.search_done)
        begin
            pos_reg       <= idx_reg;
            hold_slot_reg <= entry_slot_reg[idx_reg];
        end
        if (ctl.commit)
        begin
            out_hit_reg    <= !fail && found_reg;
            out_slot_reg   <= fail ? '0 : lbci_pkg::fit_slot(head_slot);
            out_status_reg <= fail;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_slot   = out_slot_reg;
    assign out_status = out_status_reg;

    `LBCI_ASSERT_NEXT(a_walk_restart, ctl.load, idx_reg == '0, "walk did not restart at front")
    `LBCI_ASSERT_NEXT(a_front_update, ctl.commit && !fail, valid_reg[0] && (entry_block_reg[0] == $past(blk_reg)), "front entry not updated")
    `LBCI_ASSERT_NEXT(a_fail_keeps, ctl.commit && fail, $stable(valid_reg) && out_status, "failed access changed index")
    `LBCI_ASSERT_NOW(a_commit_room, ctl.commit, !out_valid_reg || out_ready, "result overwritten before taken")

endmodule

// ===== rtl/lru_block_cache_index.sv =====
`timescale 1ns / 1ps

// channel   dir   data                                             side
// s_*       in    tdata[31:0] block_number, [32] device_ok, tuser cmd  request
// m_*       out   tdata[0] hit, [3:1] slot, [4] status             result
//
// one item at a time: an accept step, a search over 1 to ENTRIES entries
// (one entry compared per cycle), then an update step
// the result register frees the input side: a new item is taken while the
// previous result still waits on m_tready
// a finished item holds its update until the result register is free
// rst_n clears the index to all entries empty, entry i on slot i

module lru_block_cache_index
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lbci_pkg::S_DATA_W-1:0]  s_tdata,   // block_number, device_ok, zero pad
    input  logic                           s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lbci_pkg::M_DATA_W-1:0]  m_tdata    // hit, slot, status, zero pad
);

    lbci_pkg::dp_cmd_t            ctl;
    lbci_pkg::dp_stat_t           stat;
    logic                         res_hit;
    logic [lbci_pkg::SLOT_W-1:0]  res_slot;
    logic                         res_status;

    lbci_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    lbci_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .in_cmd     (s_tuser),
        .in_block   (s_tdata[lbci_pkg::BLOCK_W-1:0]),
        .in_ok      (s_tdata[lbci_pkg::BLOCK_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (res_hit),
        .out_slot   (res_slot),
        .out_status (res_status)
    );

    assign m_tdata = {{(lbci_pkg::M_DATA_W - lbci_pkg::SLOT_W - 2){1'b0}},
                      res_status, res_slot, res_hit};

endmodule
